// ----- sv/lszw_pkg.sv -----
// ----------------------------------------------------------------------------
// Lidar scan cluster package
// Shared types, widths, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lszw_pkg;

  localparam int XW = 36;  // CORDIC x/y datapath width
  localparam int ZW = 34;  // CORDIC angle accumulator width
  localparam int PW = 20;  // point coordinate width after rounding

  localparam logic [16:0] CORDIC_GAIN = 17'd39797;

  localparam logic KIND_CLUSTER = 1'b0;
  localparam logic KIND_SCAN    = 1'b1;

  localparam logic [1:0] ZONE_NEAR = 2'd0;
  localparam logic [1:0] ZONE_MID  = 2'd1;
  localparam logic [1:0] ZONE_FAR  = 2'd2;
  localparam logic [1:0] ZONE_NONE = 2'd3;

  localparam logic [2:0] REG_ROI_MIN_X = 3'd0;
  localparam logic [2:0] REG_ROI_MAX_X = 3'd1;
  localparam logic [2:0] REG_ROI_MIN_Y = 3'd2;
  localparam logic [2:0] REG_ROI_MAX_Y = 3'd3;
  localparam logic [2:0] REG_GAP       = 3'd4;
  localparam logic [2:0] REG_NEAR      = 3'd5;
  localparam logic [2:0] REG_MID       = 3'd6;
  localparam logic [2:0] REG_FAR       = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_START, S_ROT, S_CONV, S_ROI, S_SQX, S_SQY, S_SQG, S_JOIN, S_LAST
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      4'd0:  v = 34'sd536870912;
      4'd1:  v = 34'sd316933406;
      4'd2:  v = 34'sd167458908;
      4'd3:  v = 34'sd85004756;
      4'd4:  v = 34'sd42667331;
      4'd5:  v = 34'sd21354465;
      4'd6:  v = 34'sd10679838;
      4'd7:  v = 34'sd5340245;
      4'd8:  v = 34'sd2670163;
      4'd9:  v = 34'sd1335087;
      4'd10: v = 34'sd667544;
      4'd11: v = 34'sd333772;
      4'd12: v = 34'sd166886;
      4'd13: v = 34'sd83443;
      4'd14: v = 34'sd41722;
      4'd15: v = 34'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/lszw_cordic.sv -----
// ----------------------------------------------------------------------------
// Lidar scan cluster CORDIC
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, 16 steps.
// ----------------------------------------------------------------------------
module lszw_cordic
  import lszw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [XW-1:0] x0,
  input  logic signed [ZW-1:0] z0,
  output cordic_stat_t         stat,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out
);

  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [3:0]           i_r;
  logic                 busy_r, done_r;

  // shared shift/add unit: one micro-rotation
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    if (!z_r[ZW-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_lut(i_r);
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_lut(i_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 4'd1;
        if (i_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      y_r <= '0;
      z_r <= z0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign x_out     = x_r;
  assign y_out     = y_r;

endmodule

// ----- sv/lidar_scan_cluster_zone_warning.sv -----
// ----------------------------------------------------------------------------
// Lidar scan cluster zone warning
// Polar-to-Cartesian conversion, ROI gating, gap clustering and zone report.
// ----------------------------------------------------------------------------
// Sequence: a valid beam inside the ROI passes from accept to the cluster
//   decision load through the gain multiply, CORDIC start, 16 CORDIC steps
//   plus done, rounding, ROI test, 3 shared-multiplier squares and decision.
// Pacing: a new beam is accepted only once the previous one is through;
//   a last beam that closes a cluster issues that cluster before the summary.
//   A result waiting in the output register stalls only a further result.
// Reset (rst_n low, synchronous): control registers take their reset values,
//   scan state goes to the origin with no open cluster; payload is not reset.
module lidar_scan_cluster_zone_warning
  import lszw_pkg::*;
#(
  parameter int MAX_BEAMS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // range_mm[15:0], beam_angle[31:16]
  input  logic        in_tuser,   // range_valid
  input  logic        in_tlast,   // last_beam
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // min_range_mm[15:0], point_count[27:16],
                                  // zone[29:28], cluster_total[41:30], zero pad
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,  // last_of_run
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CAP_INT = (MAX_BEAMS < 4095) ? MAX_BEAMS : 4095;
  localparam logic [11:0] CNT_CAP = 12'(CAP_INT);

  // ---------------- configuration registers ----------------
  logic signed [16:0] roi_min_x_r, roi_max_x_r, roi_min_y_r, roi_max_y_r;
  logic [15:0]        gap_r, near_r, mid_r, far_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_min_x_r <= 17'sd100;
      roi_max_x_r <= 17'sd10000;
      roi_min_y_r <= -17'sd1000;
      roi_max_y_r <= 17'sd1000;
      gap_r       <= 16'd300;
      near_r      <= 16'd1000;
      mid_r       <= 16'd4500;
      far_r       <= 16'd7000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROI_MIN_X: roi_min_x_r <= cfg_pwdata[16:0];
        REG_ROI_MAX_X: roi_max_x_r <= cfg_pwdata[16:0];
        REG_ROI_MIN_Y: roi_min_y_r <= cfg_pwdata[16:0];
        REG_ROI_MAX_Y: roi_max_y_r <= cfg_pwdata[16:0];
        REG_GAP:       gap_r       <= cfg_pwdata[15:0];
        REG_NEAR:      near_r      <= cfg_pwdata[15:0];
        REG_MID:       mid_r       <= cfg_pwdata[15:0];
        REG_FAR:       far_r       <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROI_MIN_X: cfg_prdata = 32'(roi_min_x_r);
      REG_ROI_MAX_X: cfg_prdata = 32'(roi_max_x_r);
      REG_ROI_MIN_Y: cfg_prdata = 32'(roi_min_y_r);
      REG_ROI_MAX_Y: cfg_prdata = 32'(roi_max_y_r);
      REG_GAP:       cfg_prdata = {16'd0, gap_r};
      REG_NEAR:      cfg_prdata = {16'd0, near_r};
      REG_MID:       cfg_prdata = {16'd0, mid_r};
      REG_FAR:       cfg_prdata = {16'd0, far_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // zone chain, applied in order as configured
  function automatic logic [1:0] zone_of(input logic [15:0] r, input logic [15:0] n,
                                         input logic [15:0] m, input logic [15:0] f);
    logic [1:0] z;
    priority if (r < n) z = ZONE_NEAR;
    else if (r < m)     z = ZONE_MID;
    else if (r < f)     z = ZONE_FAR;
    else                z = ZONE_NONE;
    return z;
  endfunction

  // ---------------- sequencer state ----------------
  state_t state_r, state_nxt;

  // beam latched at accept
  logic [15:0]        rng_r, rng_nxt;
  logic               last_r, last_nxt, flip_r, flip_nxt;
  logic signed [16:0] ang_r, ang_nxt;

  // work registers
  logic signed [39:0] prod_r, prod_nxt;   // shared multiplier result / d2 accumulator
  logic signed [PW-1:0] px_r, px_nxt, py_r, py_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic               join_r, join_nxt;

  // scan state
  logic signed [17:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic               open_r, open_nxt;
  logic [15:0]        cmin_r, cmin_nxt, smin_r, smin_nxt;
  logic [11:0]        cpts_r, cpts_nxt, ccnt_r, ccnt_nxt;

  // output register
  logic        ov_r, ov_nxt, okind_r, okind_nxt, olast_r, olast_nxt;
  logic [15:0] omin_r, omin_nxt;
  logic [11:0] opts_r, opts_nxt, otot_r, otot_nxt;
  logic [1:0]  ozone_r, ozone_nxt;

  // shared multiplier
  logic signed [19:0] mul_a, mul_b;
  logic signed [39:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // CORDIC
  logic                 cs_start;
  cordic_stat_t         cs_stat;
  logic signed [XW-1:0] cx, cy, x0;
  logic signed [ZW-1:0] z0;

  assign x0 = prod_r[XW-1:0];
  // angle times 65536, sign-extended to the accumulator width
  assign z0 = {ang_r[16], ang_r, 16'd0};

  lszw_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .x0    (x0),
    .z0    (z0),
    .stat  (cs_stat),
    .x_out (cx),
    .y_out (cy)
  );

  // combinational helpers
  logic signed [16:0]   a17;
  logic signed [XW-1:0] xr, yr;
  logic signed [PW-1:0] pxr, pyr;
  logic                 in_roi, slot_free, need_close;
  logic [11:0]          ccnt_inc, cpts_inc;
  logic [15:0]          cmin_min, smin_min;

  assign slot_free = !ov_r || out_tready;
  assign ccnt_inc  = (ccnt_r < CNT_CAP) ? ccnt_r + 12'd1 : ccnt_r;
  assign cpts_inc  = (cpts_r < CNT_CAP) ? cpts_r + 12'd1 : cpts_r;
  assign cmin_min  = (rng_r < cmin_r) ? rng_r : cmin_r;
  assign smin_min  = (rng_r < smin_r) ? rng_r : smin_r;
  assign need_close = !join_r && open_r;

  always_comb begin
    a17 = 17'(signed'(in_tdata[31:16]));
    xr  = cx + XW'(32768);
    yr  = cy + XW'(32768);
    pxr = xr[XW-1:16];
    pyr = yr[XW-1:16];
    in_roi = (px_r >= PW'(roi_min_x_r)) && (px_r <= PW'(roi_max_x_r)) &&
             (py_r >= PW'(roi_min_y_r)) && (py_r <= PW'(roi_max_y_r));
  end

  always_comb begin
    state_nxt  = state_r;
    rng_nxt    = rng_r;
    last_nxt   = last_r;
    flip_nxt   = flip_r;
    ang_nxt    = ang_r;
    prod_nxt   = prod_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    join_nxt   = join_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    open_nxt   = open_r;
    cmin_nxt   = cmin_r;
    smin_nxt   = smin_r;
    cpts_nxt   = cpts_r;
    ccnt_nxt   = ccnt_r;
    ov_nxt     = ov_r && !out_tready;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    omin_nxt   = omin_r;
    opts_nxt   = opts_r;
    otot_nxt   = otot_r;
    ozone_nxt  = ozone_r;
    in_tready  = 1'b0;
    cs_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          rng_nxt  = in_tdata[15:0];
          last_nxt = in_tlast;
          // fold the angle into [-pi/2, pi/2]
          priority if (a17 > 17'sd16384) begin
            ang_nxt  = a17 - 17'sd32768;
            flip_nxt = 1'b1;
          end else if (a17 < -17'sd16384) begin
            ang_nxt  = a17 + 17'sd32768;
            flip_nxt = 1'b1;
          end else begin
            ang_nxt  = a17;
            flip_nxt = 1'b0;
          end
          state_nxt = in_tuser ? S_PRE : S_LAST;
        end
      end
      S_PRE: begin
        // gain-compensated start vector
        mul_a     = {4'd0, rng_r};
        mul_b     = 20'(CORDIC_GAIN);
        prod_nxt  = mul_p;
        state_nxt = S_START;
      end
      S_START: begin
        cs_start  = 1'b1;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (cs_stat.done) state_nxt = S_CONV;
      end
      S_CONV: begin
        // round to mm, undo the fold
        px_nxt    = flip_r ? -pxr : pxr;
        py_nxt    = flip_r ? -pyr : pyr;
        state_nxt = S_ROI;
      end
      S_ROI: begin
        dx_nxt    = px_r - PW'(prev_x_r);
        dy_nxt    = py_r - PW'(prev_y_r);
        state_nxt = in_roi ? S_SQX : S_LAST;
      end
      S_SQX: begin
        mul_a     = dx_r;
        mul_b     = dx_r;
        prod_nxt  = mul_p;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a     = dy_r;
        mul_b     = dy_r;
        prod_nxt  = prod_r + mul_p;
        state_nxt = S_SQG;
      end
      S_SQG: begin
        mul_a     = {4'd0, gap_r};
        mul_b     = {4'd0, gap_r};
        join_nxt  = prod_r < mul_p;
        state_nxt = S_JOIN;
      end
      S_JOIN: begin
        if (!need_close || slot_free) begin
          if (need_close) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_CLUSTER;
            omin_nxt  = cmin_r;
            opts_nxt  = cpts_r;
            ozone_nxt = zone_of(cmin_r, near_r, mid_r, far_r);
            otot_nxt  = ccnt_inc;
            olast_nxt = !last_r;
            ccnt_nxt  = ccnt_inc;
            cpts_nxt  = 12'd1;
            cmin_nxt  = rng_r;
          end else begin
            cpts_nxt  = cpts_inc;
            cmin_nxt  = cmin_min;
          end
          open_nxt   = 1'b1;
          smin_nxt   = smin_min;
          prev_x_nxt = px_r[17:0];
          prev_y_nxt = py_r[17:0];
          state_nxt  = S_LAST;
        end
      end
      S_LAST: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          ov_nxt = 1'b1;
          if (open_r) begin
            // close the open cluster before the summary
            okind_nxt = KIND_CLUSTER;
            omin_nxt  = cmin_r;
            opts_nxt  = cpts_r;
            ozone_nxt = zone_of(cmin_r, near_r, mid_r, far_r);
            otot_nxt  = ccnt_inc;
            olast_nxt = 1'b0;
            ccnt_nxt  = ccnt_inc;
            open_nxt  = 1'b0;
            cmin_nxt  = 16'hFFFF;
            cpts_nxt  = '0;
          end else begin
            okind_nxt  = KIND_SCAN;
            omin_nxt   = smin_r;
            opts_nxt   = '0;
            ozone_nxt  = (ccnt_r == 12'd0) ? ZONE_NONE
                                           : zone_of(smin_r, near_r, mid_r, far_r);
            otot_nxt   = ccnt_r;
            olast_nxt  = 1'b1;
            prev_x_nxt = '0;
            prev_y_nxt = '0;
            cmin_nxt   = 16'hFFFF;
            cpts_nxt   = '0;
            ccnt_nxt   = '0;
            smin_nxt   = 16'hFFFF;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      open_r   <= 1'b0;
      cmin_r   <= 16'hFFFF;
      smin_r   <= 16'hFFFF;
      cpts_r   <= '0;
      ccnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      open_r   <= open_nxt;
      cmin_r   <= cmin_nxt;
      smin_r   <= smin_nxt;
      cpts_r   <= cpts_nxt;
      ccnt_r   <= ccnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rng_r   <= rng_nxt;
    last_r  <= last_nxt;
    flip_r  <= flip_nxt;
    ang_r   <= ang_nxt;
    prod_r  <= prod_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    join_r  <= join_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
    omin_r  <= omin_nxt;
    opts_r  <= opts_nxt;
    otot_r  <= otot_nxt;
    ozone_r <= ozone_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, otot_r, ozone_r, opts_r, omin_r};

endmodule

// ----- sv/lszw_checker.sv -----
// ----------------------------------------------------------------------------
// Lidar scan cluster checker
// Port-level assertions on the result stream and input pacing.
// ----------------------------------------------------------------------------
module lszw_checker
  import lszw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // an accepted beam keeps the input closed for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input reopened right after accept");

  a_scan_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SCAN) |-> out_tlast)
    else $error("scan summary not last of run");

  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SCAN) |-> out_tdata[27:16] == 12'd0)
    else $error("scan summary with nonzero point count");

  a_clu_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CLUSTER) |->
      out_tdata[27:16] != 12'd0 && out_tdata[41:30] != 12'd0)
    else $error("cluster summary with zero count");

endmodule

bind lidar_scan_cluster_zone_warning lszw_checker u_lszw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
